// File: sv/led_pwm_frame_builder_unit_defines.svh
// Assertion macros shared by the checker files of the frame builder.
`ifndef LED_PWM_FRAME_BUILDER_UNIT_DEFINES_SVH
`define LED_PWM_FRAME_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

// File: sv/lpfb_pkg.sv
package lpfb_pkg;

    // Fixed geometry of one driver in the chain.
    localparam int CHANNELS_PER_DRIVER = 12;
    localparam int DEFAULT_MAX_DRIVERS = 8;
    localparam int WORDS_PER_DRIVER    = 7;
    localparam int WORD_W              = 3;

    // Field widths.
    localparam int OP_W       = 2;
    localparam int CHAN_W     = 7;
    localparam int LED_W      = 6;
    localparam int LEVEL_W    = 16;
    localparam int FRAME_W    = 32;
    localparam int NUM_DRV_W  = 4;
    localparam int BRIGHT_W   = 7;
    // Wide enough for the largest channel number an LED request can name (63*3+2).
    localparam int SUM_W      = 8;

    // Configuration port.
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Header constants.
    localparam logic [5:0] HDR_MAGIC = 6'h25;
    localparam logic [4:0] HDR_FLAGS = 5'h16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SET_CHANNEL = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_LED     = 2'd1;
    localparam logic [OP_W-1:0] OP_EMIT        = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_NUM_DRIVERS = 2'd0;
    localparam logic [1:0] REG_BRIGHT_RED  = 2'd1;
    localparam logic [1:0] REG_BRIGHT_GRN  = 2'd2;
    localparam logic [1:0] REG_BRIGHT_BLU  = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WRITE = 4'b0010,
        ST_READ  = 4'b0100,
        ST_PUSH  = 4'b1000
    } state_t;

endpackage

// File: sv/led_pwm_frame_builder_unit.sv
// Channel   Handshake               Payload
// cmd       cmd_valid / cmd_stall   operation, channel_index, led_index, three levels
// frame     frame_valid/frame_stall frame_word, last_word
// config    APB write/read          num_drivers, bright_red, bright_green, bright_blue
//
// A set-channel request writes one channel and a set-LED request three: one shared
// adder and limit compare handles one channel per cycle.
// In an emit request each word is a read step of the level memory (two ports), then a push step.
// Reset clears all levels at once through per-entry valid bits; no clearing pass.
// Output stalls hold the sequencer in its push step; the request side stays stalled
// until the last word sits in the output register.
module led_pwm_frame_builder_unit #(
    parameter int MAX_DRIVERS = lpfb_pkg::DEFAULT_MAX_DRIVERS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpfb_pkg::PADDR_W-1:0]        paddr,
    input  logic [lpfb_pkg::PDATA_W-1:0]        pwdata,
    output logic [lpfb_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // Request channel
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [lpfb_pkg::OP_W-1:0]           operation,
    input  logic [lpfb_pkg::CHAN_W-1:0]         channel_index,
    input  logic [lpfb_pkg::LED_W-1:0]          led_index,
    input  logic [lpfb_pkg::LEVEL_W-1:0]        first_level,
    input  logic [lpfb_pkg::LEVEL_W-1:0]        second_level,
    input  logic [lpfb_pkg::LEVEL_W-1:0]        third_level,
    // Frame channel
    output logic                                frame_valid,
    input  logic                                frame_stall,
    output logic [lpfb_pkg::FRAME_W-1:0]        frame_word,
    output logic                                last_word
);

    localparam int DEPTH = MAX_DRIVERS * lpfb_pkg::CHANNELS_PER_DRIVER;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = lpfb_pkg::SUM_W;
    localparam int LW    = lpfb_pkg::LEVEL_W;
    localparam int DW    = lpfb_pkg::NUM_DRV_W;
    localparam int WW    = lpfb_pkg::WORD_W;
    localparam int PW    = lpfb_pkg::PDATA_W;

    // Configuration registers.
    logic [DW-1:0]                   num_drivers_reg;
    logic [lpfb_pkg::BRIGHT_W-1:0]   bright_red_reg;
    logic [lpfb_pkg::BRIGHT_W-1:0]   bright_green_reg;
    logic [lpfb_pkg::BRIGHT_W-1:0]   bright_blue_reg;

    // Sequencer state.
    lpfb_pkg::state_t  state_reg, state_next;
    logic [SW-1:0]     wr_base_reg;
    logic [1:0]        wr_idx_reg;
    logic [1:0]        wr_last_reg;
    logic [LW-1:0]     lvl_reg [3];
    logic [DW-1:0]     drv_reg;
    logic [DW-1:0]     drv_last_reg;
    logic [AW-1:0]     drv_base_reg;
    logic [WW-1:0]     word_reg;

    // Level memory and its valid bits.
    logic [LW-1:0]     mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [LW-1:0]     rd_hi_reg, rd_lo_reg;
    logic              rd_hi_ok_reg, rd_lo_ok_reg;

    // Output register.
    logic                               out_valid_reg;
    logic [lpfb_pkg::FRAME_W-1:0]       out_word_reg;
    logic                               out_last_reg;

    // Shared adder and limit compare.
    logic [SW-1:0]     unit_a, unit_b, unit_sum;
    logic              unit_in_range;
    logic [DW-1:0]     active;
    logic [SW-1:0]     limit;
    logic [3:0]        word_offset;

    logic              cmd_fire;
    logic              cfg_write;
    logic              out_free;
    logic              push;
    logic              push_last;
    logic              wr_en;
    logic [AW-1:0]     hi_addr, lo_addr;
    logic [LW-1:0]     wr_level;
    logic [lpfb_pkg::FRAME_W-1:0] header_word;
    logic [lpfb_pkg::FRAME_W-1:0] push_word;

    // Handshake decode.
    assign cmd_stall  = (state_reg != lpfb_pkg::ST_IDLE);
    assign cmd_fire   = cmd_valid && !cmd_stall;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign out_free   = !out_valid_reg || !frame_stall;

    // Effective driver count and the channel limit it sets.
    assign active = (num_drivers_reg > DW'(MAX_DRIVERS)) ? DW'(MAX_DRIVERS) : num_drivers_reg;
    assign limit  = (SW'(active) << 3) + (SW'(active) << 2);

    // Offset of the upper channel of a data word within its driver.
    always_comb
    begin
        case (word_reg)
            3'd1:    word_offset = 4'd11;
            3'd2:    word_offset = 4'd9;
            3'd3:    word_offset = 4'd7;
            3'd4:    word_offset = 4'd5;
            3'd5:    word_offset = 4'd3;
            3'd6:    word_offset = 4'd1;
            default: word_offset = 4'd0;
        endcase
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        case (state_reg)
            lpfb_pkg::ST_WRITE:
            begin
                unit_a = wr_base_reg;
                unit_b = SW'(wr_idx_reg);
            end
            lpfb_pkg::ST_READ:
            begin
                unit_a = SW'(drv_base_reg);
                unit_b = SW'(word_offset);
            end
            lpfb_pkg::ST_PUSH:
            begin
                unit_a = SW'(drv_base_reg);
                unit_b = SW'(lpfb_pkg::CHANNELS_PER_DRIVER);
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    assign unit_sum      = unit_a + unit_b;
    assign unit_in_range = (unit_sum < limit);

    // The upper channel of a data word is odd, so its partner is the even one below.
    assign hi_addr = unit_sum[AW-1:0];
    assign lo_addr = {hi_addr[AW-1:1], 1'b0};

    // Level written in the current write step.
    always_comb
    begin
        case (wr_idx_reg)
            2'd0:    wr_level = lvl_reg[0];
            2'd1:    wr_level = lvl_reg[1];
            2'd2:    wr_level = lvl_reg[2];
            default: wr_level = '0;
        endcase
    end

    assign wr_en = (state_reg == lpfb_pkg::ST_WRITE) && unit_in_range;

    // Word assembly for the push step.
    assign header_word = {lpfb_pkg::HDR_MAGIC, lpfb_pkg::HDR_FLAGS,
                          bright_red_reg, bright_green_reg, bright_blue_reg};
    assign push_word   = (word_reg == '0) ? header_word :
                         {(rd_hi_ok_reg ? rd_hi_reg : LW'(0)),
                          (rd_lo_ok_reg ? rd_lo_reg : LW'(0))};
    assign push        = (state_reg == lpfb_pkg::ST_PUSH) && out_free;
    assign push_last   = (drv_reg == drv_last_reg) &&
                         (word_reg == WW'(lpfb_pkg::WORDS_PER_DRIVER - 1));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpfb_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (operation inside {lpfb_pkg::OP_SET_CHANNEL, lpfb_pkg::OP_SET_LED})
                        state_next = lpfb_pkg::ST_WRITE;
                    else if (operation == lpfb_pkg::OP_EMIT && active != '0)
                        state_next = lpfb_pkg::ST_READ;
                end
            end
            lpfb_pkg::ST_WRITE:
            begin
                if (wr_idx_reg == wr_last_reg)
                    state_next = lpfb_pkg::ST_IDLE;
            end
            lpfb_pkg::ST_READ:
            begin
                state_next = lpfb_pkg::ST_PUSH;
            end
            lpfb_pkg::ST_PUSH:
            begin
                if (push)
                    state_next = push_last ? lpfb_pkg::ST_IDLE : lpfb_pkg::ST_READ;
            end
            default:
            begin
                state_next = lpfb_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lpfb_pkg::ST_IDLE;
            wr_idx_reg   <= '0;
            wr_last_reg  <= '0;
            drv_reg      <= '0;
            drv_last_reg <= '0;
            drv_base_reg <= '0;
            word_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_fire)
            begin
                wr_idx_reg   <= '0;
                wr_last_reg  <= (operation == lpfb_pkg::OP_SET_LED) ? 2'd2 : 2'd0;
                drv_reg      <= '0;
                drv_last_reg <= active - DW'(1);
                drv_base_reg <= '0;
                word_reg     <= '0;
            end
            else if (state_reg == lpfb_pkg::ST_WRITE)
            begin
                wr_idx_reg <= wr_idx_reg + 2'd1;
            end
            else if (push)
            begin
                if (word_reg == WW'(lpfb_pkg::WORDS_PER_DRIVER - 1))
                begin
                    word_reg     <= '0;
                    drv_reg      <= drv_reg + DW'(1);
                    drv_base_reg <= unit_sum[AW-1:0];
                end
                else
                begin
                    word_reg <= word_reg + WW'(1);
                end
            end
        end
    end

    // Request payload captured at acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            if (operation == lpfb_pkg::OP_SET_LED)
                wr_base_reg <= ({1'b0, led_index, 1'b0}) + SW'(led_index);
            else
                wr_base_reg <= SW'(channel_index);
            lvl_reg[0] <= first_level;
            lvl_reg[1] <= second_level;
            lvl_reg[2] <= third_level;
        end
    end

    // Level memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[unit_sum[AW-1:0]] <= wr_level;
        if (state_reg == lpfb_pkg::ST_READ)
        begin
            rd_hi_reg <= mem[hi_addr];
            rd_lo_reg <= mem[lo_addr];
        end
    end

    // Valid bits: an entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_hi_ok_reg <= 1'b0;
            rd_lo_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[unit_sum[AW-1:0]] <= 1'b1;
            if (state_reg == lpfb_pkg::ST_READ)
            begin
                rd_hi_ok_reg <= valid_reg[hi_addr];
                rd_lo_ok_reg <= valid_reg[lo_addr];
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (!frame_stall)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_word_reg <= push_word;
            out_last_reg <= push_last;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_word  = out_word_reg;
    assign last_word   = out_last_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_drivers_reg  <= DW'(1);
            bright_red_reg   <= '1;
            bright_green_reg <= '1;
            bright_blue_reg  <= '1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                lpfb_pkg::REG_NUM_DRIVERS: num_drivers_reg  <= pwdata[DW-1:0];
                lpfb_pkg::REG_BRIGHT_RED:  bright_red_reg   <= pwdata[lpfb_pkg::BRIGHT_W-1:0];
                lpfb_pkg::REG_BRIGHT_GRN:  bright_green_reg <= pwdata[lpfb_pkg::BRIGHT_W-1:0];
                lpfb_pkg::REG_BRIGHT_BLU:  bright_blue_reg  <= pwdata[lpfb_pkg::BRIGHT_W-1:0];
                default:                   num_drivers_reg  <= num_drivers_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            lpfb_pkg::REG_NUM_DRIVERS: prdata = PW'(num_drivers_reg);
            lpfb_pkg::REG_BRIGHT_RED:  prdata = PW'(bright_red_reg);
            lpfb_pkg::REG_BRIGHT_GRN:  prdata = PW'(bright_green_reg);
            lpfb_pkg::REG_BRIGHT_BLU:  prdata = PW'(bright_blue_reg);
            default:                   prdata = '0;
        endcase
    end

endmodule

// File: sv/lpfb_checker.sv
`include "led_pwm_frame_builder_unit_defines.svh"

module lpfb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_stall,
    input logic [lpfb_pkg::OP_W-1:0]     operation,
    input logic                          frame_valid,
    input logic                          frame_stall,
    input logic [lpfb_pkg::FRAME_W-1:0]  frame_word,
    input logic                          last_word
);

    logic set_fire;

    // A request that only updates levels.
    assign set_fire = cmd_valid && !cmd_stall &&
                      (operation inside {lpfb_pkg::OP_SET_CHANNEL, lpfb_pkg::OP_SET_LED});

    // A stalled word stays offered.
    `LPFB_ASSERT_NEXT(a_frame_hold, clk, rst_n, frame_valid && frame_stall, frame_valid)

    // A stalled word does not change.
    `LPFB_ASSERT_NEXT(a_frame_stable, clk, rst_n, frame_valid && frame_stall,
        $stable(frame_word) && $stable(last_word))

    // A level update keeps the block busy for at least its first write cycle.
    `LPFB_ASSERT_NEXT(a_set_busy, clk, rst_n, set_fire, cmd_stall)

    // A level update never produces a frame word.
    `LPFB_ASSERT_NEXT(a_set_silent, clk, rst_n, set_fire && !frame_valid, !frame_valid)

endmodule

bind led_pwm_frame_builder_unit lpfb_checker u_lpfb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .operation   (operation),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_word  (frame_word),
    .last_word   (last_word)
);
